>>> hw/rtl/normal_tangent_packer_assert.svh
// Assertion macros shared by the checker.
`ifndef NORMAL_TANGENT_PACKER_ASSERT_SVH
`define NORMAL_TANGENT_PACKER_ASSERT_SVH

// same-cycle implication
`define NTP_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define NTP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> hw/rtl/ntp_pkg.sv
package ntp_pkg;

   localparam int COMPONENT_WIDTH = 16;
   localparam int FIELD_WIDTH     = 9;
   localparam int QUOT_WIDTH      = 9;
   localparam int DIV_WIDTH       = COMPONENT_WIDTH + 8;
   localparam int WORD_WIDTH      = 32;
   localparam int PAD_WIDTH       = 10;

   localparam logic [FIELD_WIDTH-1:0] FIELD_CENTER = FIELD_WIDTH'(256);
   localparam logic signed [COMPONENT_WIDTH-1:0] UNIT_ONE =
      COMPONENT_WIDTH'(1) << (COMPONENT_WIDTH - 2);

   typedef enum logic [1:0] {
      DROP_X = 2'd0,
      DROP_Y = 2'd1,
      DROP_Z = 2'd2
   } drop_idx_type;

   typedef struct packed {
      logic signed [COMPONENT_WIDTH-1:0] normal_x;
      logic signed [COMPONENT_WIDTH-1:0] normal_y;
      logic signed [COMPONENT_WIDTH-1:0] normal_z;
      logic signed [COMPONENT_WIDTH-1:0] tangent_w;
   } ntp_req_type;

   typedef struct packed {
      logic [WORD_WIDTH-1:0] packed_word;
      logic                  degenerate;
   } ntp_rsp_type;

   typedef struct packed {
      logic                       flag;
      drop_idx_type               idx;
      logic                       sgn;
      logic                       degen;
      logic [COMPONENT_WIDTH-1:0] dvsr;
      logic [DIV_WIDTH-1:0]       rem_hi;
      logic [DIV_WIDTH-1:0]       rem_lo;
      logic [QUOT_WIDTH-1:0]      q_hi;
      logic [QUOT_WIDTH-1:0]      q_lo;
   } ntp_stage_type;

endpackage

>>> hw/rtl/normal_tangent_packer.sv
// Packs one normal plus tangent w per cycle into a 32-bit word. A front stage
// picks the dropped component and forms the dividends, then a row of nine
// restoring-division cells settles one quotient bit of both kept fields each.
// A transaction passes the front register, then the nine cell registers,
// before rsp_valid; throughput is one transaction per cycle while rsp_ready
// stays high, and front and row hold up to ten transactions under backpressure.
module normal_tangent_packer (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  ntp_pkg::ntp_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output ntp_pkg::ntp_rsp_type rsp_data
);
   import ntp_pkg::*;

   logic          valid_w [QUOT_WIDTH+1];
   logic          ready_w [QUOT_WIDTH+1];
   ntp_stage_type stage_w [QUOT_WIDTH+1];
   ntp_stage_type last;
   logic [FIELD_WIDTH-1:0] hi, lo;

   ntp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .valid_in  (req_valid),
      .ready_out (req_ready),
      .req_in    (req_data),
      .valid_out (valid_w[0]),
      .ready_in  (ready_w[0]),
      .stage_out (stage_w[0])
   );

   for (genvar k = 0; k < QUOT_WIDTH; k++) begin : g_cell
      ntp_cell #(
         .BIT_POS (QUOT_WIDTH - 1 - k)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .valid_in  (valid_w[k]),
         .ready_out (ready_w[k]),
         .stage_in  (stage_w[k]),
         .valid_out (valid_w[k+1]),
         .ready_in  (ready_w[k+1]),
         .stage_out (stage_w[k+1])
      );
   end

   assign ready_w[QUOT_WIDTH] = rsp_ready;
   assign last                = stage_w[QUOT_WIDTH];
   assign rsp_valid           = valid_w[QUOT_WIDTH];

   always_comb begin
      hi = last.degen ? FIELD_CENTER : (last.q_hi + FIELD_WIDTH'(1));
      lo = last.degen ? FIELD_CENTER : (last.q_lo + FIELD_WIDTH'(1));
      rsp_data.packed_word = {last.flag, last.idx, last.sgn, hi, lo,
                              PAD_WIDTH'(0)};
      rsp_data.degenerate  = last.degen;
   end
endmodule

>>> hw/rtl/ntp_front.sv
module ntp_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 valid_in,
   output logic                 ready_out,
   input  ntp_pkg::ntp_req_type req_in,
   output logic                 valid_out,
   input  logic                 ready_in,
   output ntp_pkg::ntp_stage_type stage_out
);
   import ntp_pkg::*;

   logic                        valid_ff, valid_in_w;
   ntp_stage_type               stage_ff, stage_in;
   logic [COMPONENT_WIDTH-1:0]  ax, ay, az, dmag;
   logic signed [COMPONENT_WIDTH-1:0] dv, vh, vl;
   drop_idx_type                idx;
   logic [COMPONENT_WIDTH:0]    sh, sl;
   logic [DIV_WIDTH:0]          nh, nl;

   function automatic logic [COMPONENT_WIDTH-1:0] absval(
      input logic signed [COMPONENT_WIDTH-1:0] v);
      absval = v[COMPONENT_WIDTH-1] ? (~v + COMPONENT_WIDTH'(1)) : v;
   endfunction

   always_comb begin
      ax = absval(req_in.normal_x);
      ay = absval(req_in.normal_y);
      az = absval(req_in.normal_z);
      if (ax >= ay && ax >= az) begin
         idx = DROP_X; dv = req_in.normal_x; dmag = ax;
         vh = req_in.normal_y; vl = req_in.normal_z;
      end else if (ay >= az) begin
         idx = DROP_Y; dv = req_in.normal_y; dmag = ay;
         vh = req_in.normal_z; vl = req_in.normal_x;
      end else begin
         idx = DROP_Z; dv = req_in.normal_z; dmag = az;
         vh = req_in.normal_x; vl = req_in.normal_y;
      end
      // 255 * (v + d), never negative
      sh = {vh[COMPONENT_WIDTH-1], vh} + {1'b0, dmag};
      sl = {vl[COMPONENT_WIDTH-1], vl} + {1'b0, dmag};
      nh = {sh, 8'd0} - {8'd0, sh};
      nl = {sl, 8'd0} - {8'd0, sl};

      stage_in.flag   = (req_in.tangent_w < UNIT_ONE);
      stage_in.idx    = idx;
      stage_in.sgn    = dv[COMPONENT_WIDTH-1];
      stage_in.degen  = (dmag == '0);
      stage_in.dvsr   = dmag;
      stage_in.rem_hi = nh[DIV_WIDTH-1:0];
      stage_in.rem_lo = nl[DIV_WIDTH-1:0];
      stage_in.q_hi   = '0;
      stage_in.q_lo   = '0;
   end

   assign ready_out  = !valid_ff || ready_in;
   assign valid_in_w = ready_out ? valid_in : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in_w;
      end
   end

   always_ff @(posedge clock) begin
      if (ready_out && valid_in) begin
         stage_ff <= stage_in;
      end
   end

   assign valid_out = valid_ff;
   assign stage_out = stage_ff;
endmodule

>>> hw/rtl/ntp_cell.sv
module ntp_cell #(
   parameter int BIT_POS = 0
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   valid_in,
   output logic                   ready_out,
   input  ntp_pkg::ntp_stage_type stage_in,
   output logic                   valid_out,
   input  logic                   ready_in,
   output ntp_pkg::ntp_stage_type stage_out
);
   import ntp_pkg::*;

   logic                 valid_ff, valid_in_w;
   ntp_stage_type        stage_ff, stage_nx;
   logic [DIV_WIDTH-1:0] dshift;
   logic                 take_hi, take_lo;

   always_comb begin
      dshift   = DIV_WIDTH'(stage_in.dvsr) << BIT_POS;
      take_hi  = (stage_in.rem_hi >= dshift);
      take_lo  = (stage_in.rem_lo >= dshift);
      stage_nx = stage_in;
      if (take_hi) begin
         stage_nx.rem_hi = stage_in.rem_hi - dshift;
      end
      if (take_lo) begin
         stage_nx.rem_lo = stage_in.rem_lo - dshift;
      end
      stage_nx.q_hi = {stage_in.q_hi[QUOT_WIDTH-2:0], take_hi};
      stage_nx.q_lo = {stage_in.q_lo[QUOT_WIDTH-2:0], take_lo};
   end

   assign ready_out  = !valid_ff || ready_in;
   assign valid_in_w = ready_out ? valid_in : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in_w;
      end
   end

   always_ff @(posedge clock) begin
      if (ready_out && valid_in) begin
         stage_ff <= stage_nx;
      end
   end

   assign valid_out = valid_ff;
   assign stage_out = stage_ff;
endmodule

>>> hw/rtl/ntp_checker.sv
`include "normal_tangent_packer_assert.svh"

module ntp_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input ntp_pkg::ntp_req_type req_data,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input ntp_pkg::ntp_rsp_type rsp_data
);
   import ntp_pkg::*;

   logic       unused_in;
   logic [1:0] rsp_idx;
   logic       degen_word_ok;

   assign unused_in = req_valid & req_ready & (^req_data);
   assign rsp_idx   = rsp_data.packed_word[30:29];
   assign degen_word_ok =
      (rsp_data.packed_word[30:10] == {DROP_X, 1'b0, FIELD_CENTER, FIELD_CENTER});

   `NTP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `NTP_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_data))
   `NTP_ASSERT_IMPL(a_pad_zero, clock, reset, rsp_valid, rsp_data.packed_word[9:0] == 10'd0)
   `NTP_ASSERT_IMPL(a_idx_legal, clock, reset, rsp_valid, rsp_idx <= DROP_Z)
   `NTP_ASSERT_IMPL(a_degen_center, clock, reset, rsp_valid && rsp_data.degenerate, degen_word_ok)
endmodule

bind normal_tangent_packer ntp_checker u_ntp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

>>> tb/tb_normal_tangent_packer.sv
module tb_normal_tangent_packer;
   timeunit 1ns;
   timeprecision 1ps;

   import ntp_pkg::*;

   localparam int RANDOM_VERTICES = 700;
   localparam int HOLD_CYCLES     = 80;
   localparam int STALL_LIMIT     = 2000;
   localparam int TAIL_CYCLES     = 20;

   typedef logic signed [COMPONENT_WIDTH-1:0] comp_type;
   typedef logic [FIELD_WIDTH-1:0] field_type;

   localparam comp_type COMP_MIN = {1'b1, {(COMPONENT_WIDTH-1){1'b0}}};
   localparam comp_type COMP_MAX = {1'b0, {(COMPONENT_WIDTH-1){1'b1}}};

   typedef struct {
      ntp_req_type vtx;
      bit          typed;
      ntp_rsp_type word;
   } vertex_row_type;

   logic        clock;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   ntp_req_type req_data  = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   ntp_rsp_type rsp_data;

   ntp_rsp_type    vertex_offer_q[$];
   ntp_rsp_type    packed_due_q[$];
   vertex_row_type vertex_rows[$];
   int             vertices_taken = 0;
   int             stall_cycles   = 0;
   int             errors         = 0;

   normal_tangent_packer DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // 256 + floor(255 * v / d), d > 0
   function automatic field_type scaled_field(longint v, longint d);
      longint n;
      longint q;
      n = 255 * v;
      q = n / d;
      if (n % d != 0 && n < 0)
         q--;
      return field_type'(256 + q);
   endfunction

   function automatic ntp_rsp_type pack_normal(ntp_req_type r);
      longint       x, y, z, w, ax, ay, az, mag_d, dv;
      drop_idx_type idx;
      field_type    hi, lo;
      logic         flag, sgn, degen;
      ntp_rsp_type  o;
      x = $signed(r.normal_x);
      y = $signed(r.normal_y);
      z = $signed(r.normal_z);
      w = $signed(r.tangent_w);
      ax = x < 0 ? -x : x;
      ay = y < 0 ? -y : y;
      az = z < 0 ? -z : z;
      if (ax >= ay && ax >= az) begin
         idx = DROP_X; dv = x; mag_d = ax;
      end else if (ay >= az) begin
         idx = DROP_Y; dv = y; mag_d = ay;
      end else begin
         idx = DROP_Z; dv = z; mag_d = az;
      end
      sgn   = dv < 0;
      degen = 1'b0;
      if (mag_d == 0) begin
         degen = 1'b1;
         hi = FIELD_CENTER;
         lo = FIELD_CENTER;
      end else begin
         case (idx)
            DROP_X: begin
               hi = scaled_field(y, mag_d);
               lo = scaled_field(z, mag_d);
            end
            DROP_Y: begin
               hi = scaled_field(z, mag_d);
               lo = scaled_field(x, mag_d);
            end
            default: begin
               hi = scaled_field(x, mag_d);
               lo = scaled_field(y, mag_d);
            end
         endcase
      end
      flag = w < longint'(UNIT_ONE);
      o.packed_word = {flag, idx, sgn, hi, lo, {PAD_WIDTH{1'b0}}};
      o.degenerate  = degen;
      return o;
   endfunction

   function automatic bit quiet_span();
      return vertices_taken >= 300 && vertices_taken < 420;
   endfunction

   function automatic comp_type extreme_comp();
      case ($urandom_range(5, 0))
         0:       return COMP_MIN;
         1:       return COMP_MIN + comp_type'(1);
         2:       return comp_type'(-1);
         3:       return comp_type'(0);
         4:       return comp_type'(1);
         default: return COMP_MAX;
      endcase
   endfunction

   function automatic comp_type flip(comp_type m);
      return $urandom_range(1, 0) ? -m : m;
   endfunction

   function automatic ntp_req_type random_vertex();
      ntp_req_type v;
      comp_type    m;
      v = ntp_req_type'({$urandom, $urandom});
      m = comp_type'($urandom);
      case ($urandom_range(9, 0))
         0: begin
            v.normal_x = comp_type'(int'($urandom_range(30, 0)) - 15);
            v.normal_y = comp_type'(int'($urandom_range(30, 0)) - 15);
            v.normal_z = comp_type'(int'($urandom_range(30, 0)) - 15);
         end
         1: begin
            v.normal_x = flip(m);
            v.normal_y = flip(m);
            if ($urandom_range(1, 0))
               v.normal_z = flip(m);
            else
               v.normal_z = m >>> 1;
         end
         2: begin
            v.normal_x = m >>> 2;
            v.normal_y = flip(m);
            v.normal_z = flip(m);
         end
         3: begin
            if ($urandom_range(1, 0)) v.normal_x = '0;
            if ($urandom_range(1, 0)) v.normal_y = '0;
            if ($urandom_range(1, 0)) v.normal_z = '0;
         end
         4: begin
            v.normal_x = extreme_comp();
            v.normal_y = extreme_comp();
            v.normal_z = extreme_comp();
            v.tangent_w = extreme_comp();
         end
         default: ;
      endcase
      if ($urandom_range(3, 0) == 0)
         v.tangent_w = UNIT_ONE + comp_type'(int'($urandom_range(4, 0)) - 2);
      return v;
   endfunction

   task automatic add_row(input int x, input int y, input int z, input int w,
                          input bit typed, input logic [31:0] word, input logic degen);
      vertex_row_type row;
      row.vtx.normal_x      = comp_type'(x);
      row.vtx.normal_y      = comp_type'(y);
      row.vtx.normal_z      = comp_type'(z);
      row.vtx.tangent_w     = comp_type'(w);
      row.typed             = typed;
      row.word.packed_word  = word;
      row.word.degenerate   = degen;
      vertex_rows.push_back(row);
   endtask

   task automatic send_vertex(input ntp_req_type vtx, input ntp_rsp_type due);
      if (!quiet_span() && $urandom_range(99, 0) < 9) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= vtx;
      vertex_offer_q.push_back(due);
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic check_rsp(input ntp_rsp_type got);
      ntp_rsp_type due;
      if (packed_due_q.size() == 0) begin
         $error("unexpected transaction: packed_word %h degenerate %b",
                got.packed_word, got.degenerate);
         errors++;
      end else begin
         due = packed_due_q.pop_front();
         if (got.packed_word !== due.packed_word) begin
            $error("packed_word expected %h actual %h", due.packed_word, got.packed_word);
            errors++;
         end
         if (got.degenerate !== due.degenerate) begin
            $error("degenerate expected %b actual %b", due.degenerate, got.degenerate);
            errors++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            packed_due_q.push_back(vertex_offer_q.pop_front());
            vertices_taken++;
         end
         if (rsp_valid && rsp_ready)
            check_rsp(rsp_data);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            stall_cycles = 0;
         else
            stall_cycles++;
      end
   end

   initial begin
      while (stall_cycles < STALL_LIMIT) @(posedge clock);
      $display("tb_normal_tangent_packer: done, errors");
      $finish;
   end

   initial begin
      bit held;
      held = 1'b0;
      wait (!reset);
      forever begin
         @(posedge clock);
         if (!held && vertices_taken >= 120) begin
            held = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_ready <= quiet_span() || $urandom_range(99, 0) >= 9;
      end
   end

   initial begin
      ntp_req_type vtx;
      add_row(0, 0, 0, 0, 1, 32'h8804_0000, 1'b1);
      add_row(0, 0, 0, 32767, 1, 32'h0804_0000, 1'b1);
      add_row(0, 0, 0, -32768, 1, 32'h8804_0000, 1'b1);
      add_row(32767, 0, 0, 16384, 1, 32'h0804_0000, 1'b0);
      add_row(0, -32768, 0, 32767, 1, 32'h3804_0000, 1'b0);
      add_row(0, 0, 32767, -32768, 1, 32'hC804_0000, 1'b0);
      add_row(16384, 16384, 16384, 16383, 1, 32'h8FFF_FC00, 1'b0);
      add_row(-32768, 32767, -32768, 16384, 0, '0, 1'b0);
      add_row(-32768, -32768, -32768, 16383, 0, '0, 1'b0);
      add_row(32767, -32767, 32767, 0, 0, '0, 1'b0);
      add_row(1, 0, 0, 1, 0, '0, 1'b0);
      add_row(-1, 1, -1, -1, 0, '0, 1'b0);
      add_row(0, 0, 1, 20000, 0, '0, 1'b0);
      add_row(0, 0, -1, 20000, 0, '0, 1'b0);
      add_row(0, 100, -100, 5, 0, '0, 1'b0);
      add_row(5, -32768, 32767, 16384, 0, '0, 1'b0);
      add_row(3, -7, -32768, 16383, 0, '0, 1'b0);
      add_row(12345, -23456, 30000, -1, 0, '0, 1'b0);
      add_row(-32767, 32767, -32766, 32767, 0, '0, 1'b0);
      add_row(21845, -21846, 10922, 16385, 0, '0, 1'b0);
      add_row(-3, 2, 1, -16384, 0, '0, 1'b0);
      add_row(-1234, -5678, 5677, 8191, 0, '0, 1'b0);

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (vertex_rows[i])
         send_vertex(vertex_rows[i].vtx,
                     vertex_rows[i].typed ? vertex_rows[i].word
                                          : pack_normal(vertex_rows[i].vtx));
      for (int i = 0; i < RANDOM_VERTICES; i++) begin
         vtx = random_vertex();
         send_vertex(vtx, pack_normal(vtx));
      end
      req_valid <= 1'b0;

      while (packed_due_q.size() != 0 || vertex_offer_q.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (errors == 0)
         $display("tb_normal_tangent_packer: done, clean");
      else
         $display("tb_normal_tangent_packer: done, errors");
      $finish;
   end

endmodule
